FILE: src/q4sd_pkg.sv
// ----------------------------------------------------------------------------
// q4sd_pkg
// shared widths, lane indexes and helpers for the quad4 shape derivative block
// ----------------------------------------------------------------------------
package q4sd_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int LOCAL_W = 18;
    localparam int COORD_W = 32;
    localparam int DERIV_W = 32;
    localparam int DET_W   = 48;
    localparam int NODES   = 4;
    localparam int LANES   = 2 * NODES;

    localparam int IN_TDATA_W  = ((2 * LOCAL_W + 2 * NODES * COORD_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((LANES * DERIV_W + DET_W + 7) / 8) * 8;

    // generator terms: one - eta, one + eta, one - xi, one + xi
    localparam int G_U = 0;
    localparam int G_V = 1;
    localparam int G_P = 2;
    localparam int G_R = 3;

    // jacobian sums, scaled by 4 * 2^frac
    localparam int S00 = 0;
    localparam int S01 = 1;
    localparam int S10 = 2;
    localparam int S11 = 3;

    typedef struct packed {
        logic valid;
        logic singular;
    } res_ctl_t;

    // width of the one +/- local coordinate terms
    function automatic int gen_w(input int f);
        return ((f > LOCAL_W - 1) ? f : LOCAL_W - 1) + 2;
    endfunction

    // width of a jacobian sum
    function automatic int sum_w(input int f);
        return gen_w(f) + COORD_W + 2;
    endfunction

    // width of the determinant numerator
    function automatic int q_w(input int f);
        return 2 * sum_w(f) + 1;
    endfunction

    // width of an adjugate numerator
    function automatic int num_w(input int f);
        return gen_w(f) + sum_w(f) + 2;
    endfunction

endpackage

FILE: src/q4sd_front.sv
// ----------------------------------------------------------------------------
// q4sd_front
// local derivative terms, corner differences and the four jacobian sums
// ----------------------------------------------------------------------------
module q4sd_front #(
    parameter int FRAC_BITS = q4sd_pkg::FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  logic signed [q4sd_pkg::LOCAL_W-1:0] xi,
    input  logic signed [q4sd_pkg::LOCAL_W-1:0] eta,
    input  logic signed [q4sd_pkg::COORD_W-1:0] px [q4sd_pkg::NODES],
    input  logic signed [q4sd_pkg::COORD_W-1:0] py [q4sd_pkg::NODES],
    output logic out_valid,
    output logic signed [q4sd_pkg::gen_w(FRAC_BITS)-1:0] gen [q4sd_pkg::NODES],
    output logic signed [q4sd_pkg::sum_w(FRAC_BITS)-1:0] jsum [q4sd_pkg::NODES]
);
    import q4sd_pkg::*;

    localparam int GW = gen_w(FRAC_BITS);
    localparam int DW = COORD_W + 1;
    localparam int MW = GW + DW;
    localparam int SW = sum_w(FRAC_BITS);
    localparam logic signed [GW-1:0] ONE = GW'(64'sd1 <<< FRAC_BITS);

    logic                 a_valid_reg, b_valid_reg, c_valid_reg;
    logic signed [GW-1:0] a_gen_reg [NODES];
    logic signed [DW-1:0] a_dx_reg [NODES];
    logic signed [DW-1:0] a_dy_reg [NODES];
    logic signed [GW-1:0] b_gen_reg [NODES];
    logic signed [MW-1:0] b_mx_reg [NODES];
    logic signed [MW-1:0] b_my_reg [NODES];
    logic signed [GW-1:0] c_gen_reg [NODES];
    logic signed [SW-1:0] c_sum_reg [NODES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_gen_reg[G_U] <= ONE - GW'(eta);
            a_gen_reg[G_V] <= ONE + GW'(eta);
            a_gen_reg[G_P] <= ONE - GW'(xi);
            a_gen_reg[G_R] <= ONE + GW'(xi);
            // each difference pairs with the generator of the same index
            a_dx_reg[G_U] <= DW'(px[1]) - DW'(px[0]);
            a_dx_reg[G_V] <= DW'(px[2]) - DW'(px[3]);
            a_dx_reg[G_P] <= DW'(px[3]) - DW'(px[0]);
            a_dx_reg[G_R] <= DW'(px[2]) - DW'(px[1]);
            a_dy_reg[G_U] <= DW'(py[1]) - DW'(py[0]);
            a_dy_reg[G_V] <= DW'(py[2]) - DW'(py[3]);
            a_dy_reg[G_P] <= DW'(py[3]) - DW'(py[0]);
            a_dy_reg[G_R] <= DW'(py[2]) - DW'(py[1]);

            for (int k = 0; k < NODES; k++)
            begin
                b_gen_reg[k] <= a_gen_reg[k];
                b_mx_reg[k]  <= MW'(a_gen_reg[k]) * MW'(a_dx_reg[k]);
                b_my_reg[k]  <= MW'(a_gen_reg[k]) * MW'(a_dy_reg[k]);
                c_gen_reg[k] <= b_gen_reg[k];
            end

            c_sum_reg[S00] <= SW'(b_mx_reg[G_U]) + SW'(b_mx_reg[G_V]);
            c_sum_reg[S10] <= SW'(b_mx_reg[G_P]) + SW'(b_mx_reg[G_R]);
            c_sum_reg[S01] <= SW'(b_my_reg[G_U]) + SW'(b_my_reg[G_V]);
            c_sum_reg[S11] <= SW'(b_my_reg[G_P]) + SW'(b_my_reg[G_R]);
        end
    end

    assign out_valid = c_valid_reg;
    assign gen       = c_gen_reg;
    assign jsum      = c_sum_reg;

endmodule

FILE: src/q4sd_prod.sv
// ----------------------------------------------------------------------------
// q4sd_prod
// split wide products: determinant numerator and the eight adjugate numerators
// ----------------------------------------------------------------------------
module q4sd_prod #(
    parameter int FRAC_BITS = q4sd_pkg::FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  logic signed [q4sd_pkg::gen_w(FRAC_BITS)-1:0] gen [q4sd_pkg::NODES],
    input  logic signed [q4sd_pkg::sum_w(FRAC_BITS)-1:0] jsum [q4sd_pkg::NODES],
    output logic out_valid,
    output logic signed [q4sd_pkg::q_w(FRAC_BITS)-1:0] q,
    output logic signed [q4sd_pkg::num_w(FRAC_BITS)-1:0] num [q4sd_pkg::LANES]
);
    import q4sd_pkg::*;

    localparam int GW  = gen_w(FRAC_BITS);
    localparam int SW  = sum_w(FRAC_BITS);
    localparam int H   = (SW + 1) / 2;
    localparam int HW  = SW - H;
    localparam int HHW = 2 * HW;
    localparam int HLW = HW + H + 1;
    localparam int LLW = 2 * H;
    localparam int GHW = GW + HW;
    localparam int GLW = GW + H + 1;
    localparam int QPW = 2 * SW;
    localparam int QW  = q_w(FRAC_BITS);
    localparam int XW  = GW + SW;
    localparam int AW  = num_w(FRAC_BITS);

    // generator and sum feeding each of the eight cofactor products
    localparam int XG [LANES] = '{G_U, G_V, G_P, G_R, G_P, G_R, G_U, G_V};
    localparam int XS [LANES] = '{S11, S11, S01, S01, S00, S00, S10, S10};
    // determinant products s00*s11 and s01*s10
    localparam int PA [2] = '{S00, S01};
    localparam int PB [2] = '{S11, S10};

    logic signed [HW-1:0] s_hi [NODES];
    logic signed [H:0]    s_lo [NODES];
    logic [H-1:0]         s_lo_u [NODES];

    logic                  d_valid_reg, e_valid_reg, f_valid_reg;
    logic signed [HHW-1:0] d_hh_reg [2];
    logic signed [HLW-1:0] d_hl_reg [2];
    logic signed [HLW-1:0] d_lh_reg [2];
    logic [LLW-1:0]        d_ll_reg [2];
    logic signed [GHW-1:0] d_gh_reg [LANES];
    logic signed [GLW-1:0] d_gl_reg [LANES];
    logic signed [QPW-1:0] e_p_reg [2];
    logic signed [XW-1:0]  e_x_reg [LANES];
    logic signed [QW-1:0]  f_q_reg;
    logic signed [AW-1:0]  f_num_reg [LANES];
    logic signed [AW-1:0]  xa [LANES];

    always_comb
    begin
        for (int j = 0; j < NODES; j++)
        begin
            s_hi[j]   = $signed(jsum[j][SW-1:H]);
            s_lo_u[j] = jsum[j][H-1:0];
            s_lo[j]   = $signed({1'b0, jsum[j][H-1:0]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d_valid_reg <= in_valid;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
        end
    end

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            xa[k] = AW'(e_x_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // partial products over the hi and lo halves of the sums
            for (int j = 0; j < 2; j++)
            begin
                d_hh_reg[j] <= HHW'(s_hi[PA[j]]) * HHW'(s_hi[PB[j]]);
                d_hl_reg[j] <= HLW'(s_hi[PA[j]]) * HLW'(s_lo[PB[j]]);
                d_lh_reg[j] <= HLW'(s_lo[PA[j]]) * HLW'(s_hi[PB[j]]);
                d_ll_reg[j] <= LLW'(s_lo_u[PA[j]]) * LLW'(s_lo_u[PB[j]]);
            end
            for (int k = 0; k < LANES; k++)
            begin
                d_gh_reg[k] <= GHW'(gen[XG[k]]) * GHW'(s_hi[XS[k]]);
                d_gl_reg[k] <= GLW'(gen[XG[k]]) * GLW'(s_lo[XS[k]]);
            end

            for (int j = 0; j < 2; j++)
            begin
                e_p_reg[j] <= (QPW'(d_hh_reg[j]) <<< (2 * H))
                            + ((QPW'(d_hl_reg[j]) + QPW'(d_lh_reg[j])) <<< H)
                            + QPW'(d_ll_reg[j]);
            end
            for (int k = 0; k < LANES; k++)
            begin
                e_x_reg[k] <= (XW'(d_gh_reg[k]) <<< H) + XW'(d_gl_reg[k]);
            end

            f_q_reg <= QW'(e_p_reg[0]) - QW'(e_p_reg[1]);
            // x derivative numerators
            f_num_reg[0] <= xa[2] - xa[0];
            f_num_reg[1] <= xa[0] + xa[3];
            f_num_reg[2] <= xa[1] - xa[3];
            f_num_reg[3] <= -xa[1] - xa[2];
            // y derivative numerators
            f_num_reg[4] <= xa[6] - xa[4];
            f_num_reg[5] <= -xa[5] - xa[6];
            f_num_reg[6] <= xa[5] - xa[7];
            f_num_reg[7] <= xa[4] + xa[7];
        end
    end

    assign out_valid = f_valid_reg;
    assign q         = f_q_reg;
    assign num       = f_num_reg;

endmodule

FILE: src/q4sd_div.sv
// ----------------------------------------------------------------------------
// q4sd_div
// eight-lane pipelined restoring divider with saturation, plus determinant
// ----------------------------------------------------------------------------
module q4sd_div #(
    parameter int FRAC_BITS = q4sd_pkg::FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  logic signed [q4sd_pkg::q_w(FRAC_BITS)-1:0] q,
    input  logic signed [q4sd_pkg::num_w(FRAC_BITS)-1:0] num [q4sd_pkg::LANES],
    output q4sd_pkg::res_ctl_t ctl,
    output logic signed [q4sd_pkg::DERIV_W-1:0] deriv [q4sd_pkg::LANES],
    output logic signed [q4sd_pkg::DET_W-1:0] det
);
    import q4sd_pkg::*;

    localparam int QW    = q_w(FRAC_BITS);
    localparam int AW    = num_w(FRAC_BITS);
    localparam int NW    = AW + 2 * FRAC_BITS;
    localparam int QB    = DERIV_W;
    localparam int RW    = (NW > QW + QB + 1) ? NW : QW + QB + 1;
    localparam int SH    = 4 + 3 * FRAC_BITS;
    localparam int STEPS = QB;

    localparam logic [QW-1:0] DET_NEG_MAG = QW'(1) << (DET_W - 1);
    localparam logic [QW-1:0] DET_POS_MAG = DET_NEG_MAG - QW'(1);
    localparam logic signed [DET_W-1:0] DET_MIN = {1'b1, {(DET_W - 1){1'b0}}};
    localparam logic signed [DET_W-1:0] DET_MAX = {1'b0, {(DET_W - 1){1'b1}}};
    localparam logic [QB-1:0] QUO_NEG_MAG = {1'b1, {(QB - 1){1'b0}}};
    localparam logic signed [DERIV_W-1:0] DERIV_MIN = {1'b1, {(DERIV_W - 1){1'b0}}};
    localparam logic signed [DERIV_W-1:0] DERIV_MAX = {1'b0, {(DERIV_W - 1){1'b1}}};

    // operand prep stage
    logic          g_valid_reg;
    logic [QW-1:0] g_dmag_reg;
    logic          g_qneg_reg;
    logic          g_zero_reg;
    logic [NW-1:0] g_num_reg [LANES];
    logic          g_neg_reg [LANES];
    logic [AW-1:0] nmag [LANES];

    // stage 0 is the overflow check, stage k+1 holds quotient bits down to QB-1-k
    logic                    pv_reg [STEPS+1];
    logic [QW-1:0]           pd_reg [STEPS+1];
    logic                    pz_reg [STEPS+1];
    logic signed [DET_W-1:0] pdet_reg [STEPS+1];
    logic [RW-1:0]           rem_reg [STEPS+1][LANES];
    logic [QB-1:0]           quo_reg [STEPS+1][LANES];
    logic                    ovf_reg [STEPS+1][LANES];
    logic                    neg_reg [STEPS+1][LANES];

    logic [QW-1:0]           det_mag;
    logic signed [DET_W-1:0] det_next;

    // output stage
    logic                      f_valid_reg;
    logic                      f_sing_reg;
    logic signed [DERIV_W-1:0] f_deriv_reg [LANES];
    logic signed [DET_W-1:0]   f_det_reg;
    logic signed [DERIV_W-1:0] deriv_next [LANES];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            nmag[l] = num[l][AW-1] ? AW'(-num[l]) : AW'(num[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= 1'b0;
            pv_reg[0]   <= 1'b0;
        end
        else if (en)
        begin
            g_valid_reg <= in_valid;
            pv_reg[0]   <= g_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_dmag_reg <= q[QW-1] ? QW'(-q) : QW'(q);
            g_qneg_reg <= q[QW-1];
            g_zero_reg <= (q == '0);
            for (int l = 0; l < LANES; l++)
            begin
                g_num_reg[l] <= NW'(nmag[l]) << (2 * FRAC_BITS);
                g_neg_reg[l] <= num[l][AW-1] ^ q[QW-1];
            end
        end
    end

    // determinant: truncate toward zero by a shift, then saturate
    always_comb
    begin
        det_mag = g_dmag_reg >> SH;
        if (g_qneg_reg)
        begin
            det_next = (det_mag > DET_NEG_MAG) ? DET_MIN : -$signed(DET_W'(det_mag));
        end
        else
        begin
            det_next = (det_mag > DET_POS_MAG) ? DET_MAX : $signed(DET_W'(det_mag));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pd_reg[0]   <= g_dmag_reg;
            pz_reg[0]   <= g_zero_reg;
            pdet_reg[0] <= det_next;
            for (int l = 0; l < LANES; l++)
            begin
                rem_reg[0][l] <= RW'(g_num_reg[l]);
                quo_reg[0][l] <= '0;
                // quotient would not fit the magnitude bits
                ovf_reg[0][l] <= RW'(g_num_reg[l]) >= (RW'(g_dmag_reg) << QB);
                neg_reg[0][l] <= g_neg_reg[l];
            end
        end
    end

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam int BIT = QB - 1 - k;

        logic [RW-1:0] dsh;
        logic [RW:0]   diff [LANES];

        assign dsh = RW'(pd_reg[k]) << BIT;

        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                diff[l] = {1'b0, rem_reg[k][l]} - {1'b0, dsh};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                pv_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                pv_reg[k+1] <= pv_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pd_reg[k+1]   <= pd_reg[k];
                pz_reg[k+1]   <= pz_reg[k];
                pdet_reg[k+1] <= pdet_reg[k];
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[k+1][l] <= diff[l][RW] ? rem_reg[k][l] : diff[l][RW-1:0];
                    quo_reg[k+1][l] <= quo_reg[k][l] | (QB'(!diff[l][RW]) << BIT);
                    ovf_reg[k+1][l] <= ovf_reg[k][l];
                    neg_reg[k+1][l] <= neg_reg[k][l];
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (pz_reg[STEPS])
            begin
                deriv_next[l] = '0;
            end
            else if (neg_reg[STEPS][l])
            begin
                deriv_next[l] = (ovf_reg[STEPS][l] || (quo_reg[STEPS][l] > QUO_NEG_MAG))
                              ? DERIV_MIN : -$signed(quo_reg[STEPS][l]);
            end
            else
            begin
                deriv_next[l] = (ovf_reg[STEPS][l] || quo_reg[STEPS][l][QB-1])
                              ? DERIV_MAX : $signed(quo_reg[STEPS][l]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f_valid_reg <= pv_reg[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_sing_reg  <= pz_reg[STEPS];
            f_det_reg   <= pz_reg[STEPS] ? '0 : pdet_reg[STEPS];
            f_deriv_reg <= deriv_next;
        end
    end

    assign ctl.valid    = f_valid_reg;
    assign ctl.singular = f_sing_reg;
    assign deriv        = f_deriv_reg;
    assign det          = f_det_reg;

endmodule

FILE: src/quad4_global_shape_derivatives.sv
// ----------------------------------------------------------------------------
// quad4_global_shape_derivatives
// q4 isoparametric jacobian, determinant and global shape derivatives
// ----------------------------------------------------------------------------
//  channel   | direction | tdata (lsb first)                          | tuser
//  s_axis    | in        | xi, eta, node0_x, node0_y .. node3_y, pad  | -
//  m_axis    | out       | dn0_dx..dn3_dx, dn0_dy..dn3_dy, jac_det    | singular
//
//  one item per cycle sustained while the skid entry is empty
//  the divider is a 32-stage restoring divider, one quotient bit a stage
//  rst_n clears all valid bits, nothing else needs a clearing pass
//  the whole pipe advances together; an output register plus a skid entry let
//  it keep accepting while one result waits, and it stalls only when both hold
// ----------------------------------------------------------------------------
module quad4_global_shape_derivatives #(
    parameter int FRAC_BITS = q4sd_pkg::FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // xi, eta, node0_x, node0_y, node1_x, node1_y, node2_x, node2_y, node3_x, node3_y
    input  logic [q4sd_pkg::IN_TDATA_W-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // dn0_dx, dn1_dx, dn2_dx, dn3_dx, dn0_dy, dn1_dy, dn2_dy, dn3_dy, jacobian_det
    output logic [q4sd_pkg::OUT_TDATA_W-1:0] m_tdata,
    // singular
    output logic m_tuser
);
    import q4sd_pkg::*;

    localparam int GW = gen_w(FRAC_BITS);
    localparam int SW = sum_w(FRAC_BITS);
    localparam int QW = q_w(FRAC_BITS);
    localparam int AW = num_w(FRAC_BITS);
    localparam int RES_W = OUT_TDATA_W + 1;
    localparam int NODE_LSB = 2 * LOCAL_W;

    logic                       en;
    logic signed [LOCAL_W-1:0]  xi, eta;
    logic signed [COORD_W-1:0]  px [NODES];
    logic signed [COORD_W-1:0]  py [NODES];

    logic                       front_valid;
    logic signed [GW-1:0]       gen [NODES];
    logic signed [SW-1:0]       jsum [NODES];
    logic                       prod_valid;
    logic signed [QW-1:0]       q;
    logic signed [AW-1:0]       num [LANES];
    res_ctl_t                   div_ctl;
    logic signed [DERIV_W-1:0]  deriv [LANES];
    logic signed [DET_W-1:0]    det;

    logic                       push;
    logic [RES_W-1:0]           res_vec;
    logic                       out_valid_reg, out_valid_next;
    logic [RES_W-1:0]           out_data_reg, out_data_next;
    logic                       skid_valid_reg, skid_valid_next;
    logic [RES_W-1:0]           skid_data_reg, skid_data_next;

    assign en       = ~skid_valid_reg;
    assign s_tready = en;

    always_comb
    begin
        xi  = $signed(s_tdata[LOCAL_W-1:0]);
        eta = $signed(s_tdata[2*LOCAL_W-1:LOCAL_W]);
        for (int n = 0; n < NODES; n++)
        begin
            px[n] = $signed(s_tdata[NODE_LSB + 2 * n * COORD_W +: COORD_W]);
            py[n] = $signed(s_tdata[NODE_LSB + (2 * n + 1) * COORD_W +: COORD_W]);
        end
    end

    q4sd_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .xi        (xi),
        .eta       (eta),
        .px        (px),
        .py        (py),
        .out_valid (front_valid),
        .gen       (gen),
        .jsum      (jsum)
    );

    q4sd_prod #(
        .FRAC_BITS (FRAC_BITS)
    ) u_prod (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .gen       (gen),
        .jsum      (jsum),
        .out_valid (prod_valid),
        .q         (q),
        .num       (num)
    );

    q4sd_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (prod_valid),
        .q        (q),
        .num      (num),
        .ctl      (div_ctl),
        .deriv    (deriv),
        .det      (det)
    );

    always_comb
    begin
        res_vec = '0;
        for (int l = 0; l < LANES; l++)
        begin
            res_vec[l*DERIV_W +: DERIV_W] = deriv[l];
        end
        res_vec[LANES*DERIV_W +: DET_W] = det;
        res_vec[OUT_TDATA_W]            = div_ctl.singular;
    end

    assign push = div_ctl.valid & en;

    // output register with one skid entry behind it
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = res_vec;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res_vec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg[OUT_TDATA_W-1:0];
    assign m_tuser  = out_data_reg[OUT_TDATA_W];

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready && push))
        else $error("skid filled without a blocked output");

    a_stall_catches_item: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready && push) |=> skid_valid_reg)
        else $error("item leaving the pipe was dropped");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("singular result with nonzero payload");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// streams q4 points through the shape derivative block and checks every result
// against a wide-integer model of the jacobian, determinant and inverse
// ----------------------------------------------------------------------------
module testbench;

    import q4sd_pkg::*;

    typedef struct {
        logic signed [LOCAL_W-1:0] xi;
        logic signed [LOCAL_W-1:0] eta;
        logic signed [COORD_W-1:0] nx [NODES];
        logic signed [COORD_W-1:0] ny [NODES];
        bit drain;
    } point_t;

    typedef struct {
        logic [DERIV_W-1:0] dx [NODES];
        logic [DERIV_W-1:0] dy [NODES];
        logic [DET_W-1:0] det;
        logic sing;
    } deriv_t;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int WATCHDOG = 5000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic m_tuser;

    point_t pend_q[$];
    deriv_t deriv_q[$];
    point_t cur;
    bit in_acc = 0;
    int n_sent = 0;
    int n_recv = 0;
    int n_sing = 0;
    int n_err = 0;
    int idle_cyc = 0;
    int hold_cnt = 0;
    bit hold_done = 0;
    bit noidle;

    quad4_global_shape_derivatives DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #6 clk = ~clk;

    assign noidle = (n_sent >= 700) && (n_sent < 900);

    function automatic logic signed [255:0] wd(input longint signed v);
        logic signed [255:0] r;
        r = 256'(v);
        return r;
    endfunction

    function automatic logic [63:0] clamp(input logic signed [255:0] v, input int bits);
        logic signed [255:0] hi;
        logic signed [255:0] lo;
        hi = (wd(1) <<< (bits - 1)) - wd(1);
        lo = -hi - wd(1);
        if (v > hi) return hi[63:0];
        if (v < lo) return lo[63:0];
        return v[63:0];
    endfunction

    function automatic deriv_t predict_derivs(input point_t p);
        deriv_t r;
        longint signed one, xi, eta, s00, s01, s10, s11;
        longint signed gx [NODES];
        longint signed ge [NODES];
        logic signed [255:0] q, a, b;
        logic [63:0] t;
        one = longint'(1) <<< FRAC;
        xi = longint'(p.xi);
        eta = longint'(p.eta);
        gx[0] = -(one - eta); gx[1] = one - eta; gx[2] = one + eta; gx[3] = -(one + eta);
        ge[0] = -(one - xi);  ge[1] = -(one + xi); ge[2] = one + xi; ge[3] = one - xi;
        s00 = 0; s01 = 0; s10 = 0; s11 = 0;
        for (int n = 0; n < NODES; n++)
        begin
            s00 += gx[n] * longint'(p.nx[n]);
            s01 += gx[n] * longint'(p.ny[n]);
            s10 += ge[n] * longint'(p.nx[n]);
            s11 += ge[n] * longint'(p.ny[n]);
        end
        q = wd(s00) * wd(s11) - wd(s01) * wd(s10);
        t = clamp(q / (wd(1) <<< (4 + 3 * FRAC)), DET_W);
        r.det = t[DET_W-1:0];
        r.sing = (q == 0);
        for (int n = 0; n < NODES; n++)
        begin
            r.dx[n] = '0;
            r.dy[n] = '0;
            if (!r.sing)
            begin
                a = wd(gx[n]) * wd(s11) - wd(ge[n]) * wd(s01);
                b = wd(ge[n]) * wd(s00) - wd(gx[n]) * wd(s10);
                t = clamp((a <<< (2 * FRAC)) / q, DERIV_W);
                r.dx[n] = t[DERIV_W-1:0];
                t = clamp((b <<< (2 * FRAC)) / q, DERIV_W);
                r.dy[n] = t[DERIV_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_point(input point_t p);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        d[0 +: LOCAL_W] = p.xi;
        d[LOCAL_W +: LOCAL_W] = p.eta;
        for (int n = 0; n < NODES; n++)
        begin
            d[2 * LOCAL_W + 64 * n +: COORD_W] = p.nx[n];
            d[2 * LOCAL_W + 64 * n + 32 +: COORD_W] = p.ny[n];
        end
        return d;
    endfunction

    task automatic add_point(input int xi, input int eta, input int x0, input int y0,
                             input int x1, input int y1, input int x2, input int y2,
                             input int x3, input int y3, input bit drain);
        point_t p;
        p.xi = LOCAL_W'(xi); p.eta = LOCAL_W'(eta); p.drain = drain;
        p.nx[0] = x0; p.ny[0] = y0; p.nx[1] = x1; p.ny[1] = y1;
        p.nx[2] = x2; p.ny[2] = y2; p.nx[3] = x3; p.ny[3] = y3;
        pend_q.push_back(p);
    endtask

    // well-formed quad: a jittered parallelogram around a random base point
    task automatic add_random_quad(input bit drain);
        int bx, by, sx, sy, k, xi, eta;
        int jx [NODES];
        int jy [NODES];
        bx = $signed($urandom) >>> $urandom_range(6, 14);
        by = $signed($urandom) >>> $urandom_range(6, 14);
        sx = $urandom_range(1, 1 << $urandom_range(1, 22));
        sy = $urandom_range(1, 1 << $urandom_range(1, 22));
        k = $signed($urandom) >>> 12;
        for (int n = 0; n < NODES; n++)
        begin
            jx[n] = $signed($urandom) >>> $urandom_range(14, 31);
            jy[n] = $signed($urandom) >>> $urandom_range(14, 31);
        end
        xi = $urandom_range(0, 131072) - 65536;
        eta = $urandom_range(0, 131072) - 65536;
        if ($urandom_range(9) == 0) xi = $signed($urandom) >>> 14;
        if ($urandom_range(9) == 0) eta = $signed($urandom) >>> 14;
        add_point(xi, eta,
                  bx + jx[0], by + jy[0],
                  bx + sx + jx[1], by + k + jy[1],
                  bx + sx - k + jx[2], by + sy + k + jy[2],
                  bx - k + jx[3], by + sy + jy[3], drain);
    endtask

    task automatic add_noise_point();
        add_point($signed($urandom) >>> 14, $signed($urandom) >>> 14,
                  $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom, 1'b0);
    endtask

    initial
    begin
        // unit square and a general quad at extreme local points
        add_point(0, 0, 0, 0, 65536, 0, 65536, 65536, 0, 65536, 1'b0);
        add_point(65536, 65536, 0, 0, 65536, 0, 65536, 65536, 0, 65536, 1'b0);
        add_point(-65536, -65536, 0, 0, 65536, 0, 65536, 65536, 0, 65536, 1'b0);
        add_point(65536, -65536, 0, 0, 131072, 0, 196608, 131072, 0, 65536, 1'b0);
        // local point outside -1..1
        add_point(131071, -131072, 0, 0, 65536, 0, 65536, 65536, 0, 65536, 1'b0);
        add_point(-131072, 131071, -65536, -65536, 65536, -32768, 98304, 65536,
                  -32768, 65536, 1'b0);
        // singular: collapsed and collinear elements
        add_point(0, 0, 5, 5, 5, 5, 5, 5, 5, 5, 1'b0);
        add_point(0, 0, 0, 0, 65536, 0, 131072, 0, 196608, 0, 1'b0);
        add_point(65536, 65536, 0, 0, 65536, 0, 65536, 65536, 65536, 65536, 1'b0);
        // tiny determinants, the first one saturating its derivatives
        add_point(0, 0, 0, 0, 1, 0, 1, 1, 0, 1, 1'b0);
        add_point(12345, -999, 0, 0, 3, 0, 3, 2, 0, 2, 1'b0);
        // huge coordinates, large determinant
        add_point(0, 0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
        add_point(-65536, 65536, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                  32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
        // reversed winding, negative determinant; then a tiny diamond element
        add_point(20000, -30000, 0, 0, 0, 65536, 65536, 65536, 65536, 0, 1'b0);
        add_point(-1, 1, 32'hffff_ffff, 0, 0, 32'hffff_ffff, 1, 0, 0, 1, 1'b0);
        // rotated square
        add_point(32768, 16384, 0, 0, 46341, 46341, 0, 92682, -46341, 46341, 1'b0);
        for (int i = 0; i < 1250; i++)
        begin
            if (i % 8 == 7)
                add_noise_point();
            else
                add_random_quad(i == 0 || i == 1000);
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait (pend_q.size() == 0 && !s_tvalid && deriv_q.size() == 0);
        repeat (60) @(posedge clk);
        $display("sent %0d points, checked %0d results, %0d singular, %0d mismatches",
                 n_sent, n_recv, n_sing, n_err);
        $display("including a long output stall and a full drain before a later point");
        if (n_err == 0 && deriv_q.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // point driver
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_acc))
        begin
            if (pend_q.size() > 0 && !(pend_q[0].drain && deriv_q.size() > 0) &&
                (noidle || $urandom_range(99) >= 25))
            begin
                cur = pend_q.pop_front();
                s_tdata <= pack_point(cur);
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result receiver, with one long hold-off to back the pipe up
    always @(negedge clk)
    begin
        if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end
        else if (!hold_done && n_sent >= 400)
        begin
            hold_done <= 1'b1;
            hold_cnt <= 300;
            m_tready <= 1'b0;
        end
        else
            m_tready <= rst_n && (noidle || $urandom_range(99) >= 25);
    end

    // monitor and checker
    always @(posedge clk)
    begin
        deriv_t got;
        deriv_t want;
        bit bad;
        in_acc = s_tvalid && s_tready;
        if (in_acc)
        begin
            deriv_q.push_back(predict_derivs(cur));
            n_sent++;
        end
        if (m_tvalid && m_tready && rst_n)
        begin
            for (int n = 0; n < NODES; n++)
            begin
                got.dx[n] = m_tdata[32 * n +: 32];
                got.dy[n] = m_tdata[128 + 32 * n +: 32];
            end
            got.det = m_tdata[256 +: DET_W];
            got.sing = m_tuser;
            n_recv++;
            if (deriv_q.size() == 0)
            begin
                n_err++;
                if (n_err <= 10) $display("unexpected result item %0d", n_recv);
            end
            else
            begin
                want = deriv_q.pop_front();
                bad = (got.det !== want.det) || (got.sing !== want.sing);
                for (int n = 0; n < NODES; n++)
                    if (got.dx[n] !== want.dx[n] || got.dy[n] !== want.dy[n]) bad = 1;
                if (want.sing) n_sing++;
                if (bad)
                begin
                    n_err++;
                    if (n_err <= 10)
                    begin
                        $display("mismatch on item %0d", n_recv);
                        $display("  exp dx %h %h %h %h dy %h %h %h %h det %h sing %b",
                                 want.dx[0], want.dx[1], want.dx[2], want.dx[3],
                                 want.dy[0], want.dy[1], want.dy[2], want.dy[3],
                                 want.det, want.sing);
                        $display("  got dx %h %h %h %h dy %h %h %h %h det %h sing %b",
                                 got.dx[0], got.dx[1], got.dx[2], got.dx[3],
                                 got.dy[0], got.dy[1], got.dy[2], got.dy[3],
                                 got.det, got.sing);
                    end
                end
            end
        end
        if (!rst_n || in_acc || (m_tvalid && m_tready))
            idle_cyc = 0;
        else
            idle_cyc++;
        if (idle_cyc >= WATCHDOG)
        begin
            $display("watchdog expired with %0d results outstanding", deriv_q.size());
            $display("testbench failed");
            $finish;
        end
    end

endmodule
